@@ sv/ple_pkg.sv @@
package ple_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 6;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_GRAB,
    S_MOVE,
    S_DRAIN,
    S_PLACE,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PTR_INS,
    PTR_FETCH,
    PTR_DEL
  } ptr_sel_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [POS_W-1:0]   position;
    logic [63:0]        coef_bits;
    logic signed [15:0] exponent;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        out_coef_bits;
    logic signed [15:0] out_exponent;
    logic [LEN_W-1:0]   length;
    logic               is_full;
    logic               is_empty;
  } out_t;

  typedef struct packed {
    logic [63:0]        coef;
    logic signed [15:0] expo;
  } term_t;

  typedef struct packed {
    logic     load_req;
    logic     ptr_load;
    ptr_sel_e ptr_sel;
    logic     rd_en;
    logic     shift;
    logic     grab;
    logic     wr_new;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    status_e chk;
    logic    is_ins;
    logic    is_rd;
    logic    no_moves;
    logic    last_move;
  } sts_t;

endpackage

@@ sv/ple_ctrl.sv @@
module ple_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ple_pkg::sts_t     sts_i,
  output ple_pkg::cmd_t     cmd_o
);

  ple_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.ptr_sel = ple_pkg::PTR_INS;
    in_ready_o = 1'b0;
    unique case (state_q)
      ple_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ple_pkg::S_CHECK;
        end
      end
      ple_pkg::S_CHECK: begin
        if (sts_i.chk != ple_pkg::ST_OK) begin
          state_d = ple_pkg::S_DONE;
        end else if (sts_i.is_ins) begin
          if (sts_i.no_moves) begin
            state_d = ple_pkg::S_PLACE;
          end else begin
            cmd_o.ptr_load = 1'b1;
            cmd_o.ptr_sel  = ple_pkg::PTR_INS;
            state_d        = ple_pkg::S_MOVE;
          end
        end else begin
          cmd_o.ptr_load = 1'b1;
          cmd_o.ptr_sel  = ple_pkg::PTR_FETCH;
          state_d        = ple_pkg::S_FETCH;
        end
      end
      ple_pkg::S_FETCH: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ple_pkg::S_GRAB;
      end
      ple_pkg::S_GRAB: begin
        cmd_o.grab = 1'b1;
        if (sts_i.is_rd || sts_i.no_moves) begin
          state_d = ple_pkg::S_DONE;
        end else begin
          cmd_o.ptr_load = 1'b1;
          cmd_o.ptr_sel  = ple_pkg::PTR_DEL;
          state_d        = ple_pkg::S_MOVE;
        end
      end
      ple_pkg::S_MOVE: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.shift = 1'b1;
        if (sts_i.last_move) begin
          state_d = ple_pkg::S_DRAIN;
        end
      end
      ple_pkg::S_DRAIN: begin
        state_d = sts_i.is_ins ? ple_pkg::S_PLACE : ple_pkg::S_DONE;
      end
      ple_pkg::S_PLACE: begin
        cmd_o.wr_new = 1'b1;
        state_d      = ple_pkg::S_DONE;
      end
      ple_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ple_pkg::S_IDLE;
        end
      end
      default: state_d = ple_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/ple_datapath.sv @@
module ple_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ple_pkg::in_t  in_i,
  input  ple_pkg::cmd_t cmd_i,
  output ple_pkg::sts_t sts_o,
  output ple_pkg::out_t out_o
);

  localparam int unsigned AW = ple_pkg::ADDR_W;
  localparam int unsigned CW = ple_pkg::CNT_W;
  localparam int unsigned XW = ple_pkg::CMP_W;

  ple_pkg::term_t  mem_q [ple_pkg::CAPACITY];
  ple_pkg::in_t    req_q;
  ple_pkg::term_t  rd_q;
  ple_pkg::term_t  res_q;
  ple_pkg::out_t   out_q;
  logic [AW-1:0]   ptr_q;
  logic [AW-1:0]   src_q;
  logic            mv_q;
  logic [CW-1:0]   count_q, count_d;

  logic [XW-1:0]   pos_x, cnt_x;
  logic [AW-1:0]   pos_m1, cnt_m1, pos_a;
  logic            is_ins, is_del, is_rd;
  ple_pkg::status_e chk;
  logic            wr_en;
  logic [AW-1:0]   wr_addr, dst_addr, ptr_init;
  ple_pkg::term_t  wr_data;

  assign pos_x  = XW'(req_q.position);
  assign cnt_x  = XW'(count_q);
  assign pos_m1 = AW'(pos_x - XW'(1));
  assign cnt_m1 = AW'(cnt_x - XW'(1));
  assign pos_a  = AW'(pos_x);
  assign is_ins = (req_q.req_type == ple_pkg::REQ_INSERT);
  assign is_del = (req_q.req_type == ple_pkg::REQ_DELETE);
  assign is_rd  = (req_q.req_type == ple_pkg::REQ_READ);

  always_comb begin
    unique case (req_q.req_type)
      ple_pkg::REQ_INSERT: begin
        if (cnt_x == XW'(ple_pkg::CAPACITY)) begin
          chk = ple_pkg::ST_FULL;
        end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
          chk = ple_pkg::ST_RANGE;
        end else begin
          chk = ple_pkg::ST_OK;
        end
      end
      ple_pkg::REQ_DELETE, ple_pkg::REQ_READ: begin
        if (cnt_x == '0) begin
          chk = ple_pkg::ST_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          chk = ple_pkg::ST_RANGE;
        end else begin
          chk = ple_pkg::ST_OK;
        end
      end
      default: chk = ple_pkg::ST_RANGE;
    endcase
  end

  assign sts_o.chk       = chk;
  assign sts_o.is_ins    = is_ins;
  assign sts_o.is_rd     = is_rd;
  assign sts_o.no_moves  = is_ins ? (pos_x == cnt_x + XW'(1)) : (pos_x == cnt_x);
  assign sts_o.last_move = is_ins ? (ptr_q == pos_m1) : (ptr_q == cnt_m1);

  always_comb begin
    unique case (cmd_i.ptr_sel)
      ple_pkg::PTR_INS:   ptr_init = cnt_m1;
      ple_pkg::PTR_FETCH: ptr_init = pos_m1;
      ple_pkg::PTR_DEL:   ptr_init = pos_a;
      default:            ptr_init = pos_m1;
    endcase
  end

  // shifted entry lands one place up on insert, one place down on delete
  assign dst_addr = is_ins ? (src_q + AW'(1)) : (src_q - AW'(1));
  assign wr_en    = mv_q | cmd_i.wr_new;
  assign wr_addr  = cmd_i.wr_new ? pos_m1 : dst_addr;
  assign wr_data  = cmd_i.wr_new ? ple_pkg::term_t'{coef: req_q.coef_bits,
                                                    expo: req_q.exponent} : rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q  <= mem_q[ptr_q];
      src_q <= ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_i;
      res_q <= '0;
    end else if (cmd_i.grab) begin
      res_q <= rd_q;
    end
    if (cmd_i.ptr_load) begin
      ptr_q <= ptr_init;
    end else if (cmd_i.rd_en && cmd_i.shift) begin
      ptr_q <= is_ins ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
    end
    if (cmd_i.out_load) begin
      out_q.status        <= chk;
      out_q.out_coef_bits <= res_q.coef;
      out_q.out_exponent  <= res_q.expo;
      out_q.length        <= ple_pkg::LEN_W'(count_d);
      out_q.is_full       <= (count_d == CW'(ple_pkg::CAPACITY));
      out_q.is_empty      <= (count_d == '0);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.out_load && chk == ple_pkg::ST_OK) begin
      if (is_ins) begin
        count_d = count_q + CW'(1);
      end else if (is_del) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mv_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      mv_q    <= cmd_i.rd_en & cmd_i.shift;
    end
  end

  assign out_o = out_q;

endmodule

@@ sv/positional_list_engine.sv @@
// Bounded list of up to CAPACITY polynomial terms with insert, delete and read at a
// 1-based position. One request is handled at a time and each gives one result item.
// The terms sit in a memory that reads one entry and writes one entry per cycle, so a
// shift moves one term per cycle. After acceptance and the check, an error goes
// straight to the result; a read, or a delete of the last term, fetches and grabs the
// term; an insert at the end places the new term; any other insert shifts the later
// terms up, drains and places it; any other delete fetches, grabs, shifts the later
// terms down and drains. A result that has not been taken holds the next request
// in its last cycle. A new item is taken while the previous result still waits.
module positional_list_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ple_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ple_pkg::out_t out_o
);

  ple_pkg::cmd_t cmd;
  ple_pkg::sts_t sts;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ple_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_o)
  );

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in progress");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != ple_pkg::ST_OK |->
      out_o.out_coef_bits == '0 && out_o.out_exponent == '0)
    else $error("error result carries term data");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_o.is_full && out_o.is_empty) &&
      (out_o.is_empty == (out_o.length == '0)))
    else $error("full and empty flags disagree with length");

endmodule
